/* hdl/pif_pkg.sv */
// Package for the polyline intersection finder.
// Holds field widths, transaction structs, item kinds and controller states.
// No dependencies.
package pif_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int OPA_W   = 68;
  localparam int OPB_W   = 34;
  localparam int PROD_W  = OPA_W + OPB_W;
  localparam int QUO_W   = 35;
  localparam int SEG_W   = 6;
  localparam int VERT_W  = 2 * COORD_W;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_START  = 2'd2,
    KIND_NEXT   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic [SEG_W-1:0]          ref_segment;
    logic                      shared_point;
    logic                      last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD0, S_RD, S_SEG,
    S_DEN1, S_DEN2, S_DZ, S_NUM1, S_NUM2,
    S_XN1, S_XN2, S_YN1, S_YN2, S_NORM,
    S_LO, S_HI, S_CHK, S_DIVX, S_DIVY,
    S_HIT, S_NEXT, S_DONE
  } state_t;

endpackage

/* hdl/polyline_intersection_finder_top.sv */
// Top level of the polyline intersection finder: controller, vertex RAM,
// shared multiplier and divider. Depends on pif_pkg, pif_ram, pif_mul, pif_div.
//
// Kinds append, clear and start are done on acceptance and leave busy low. A
// next-vertex transaction with a previous vertex and two or more stored vertices
// walks the stored reference segments one after another, with a first read and
// a wrap-up step. A segment with a shared endpoint goes straight to a hit; else
// two products give the denominator, and a parallel pair ends there. A full
// test takes ten products, and a hit adds two quotients. Products run on the
// one-bit-per-cycle multiplier, quotients on the one-bit-per-cycle divider.
// Results come out on result, one cycle each with strobe high; the receiver
// cannot stall and must take every one. The final result of a transaction
// carries last and is strobed in the same cycle in which busy drops; busy stays
// high until the walk is over. The vertex RAM needs no clearing pass on reset.
module polyline_intersection_finder_top #(
  parameter int MAX_REF_VERTICES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pif_pkg::in_item_t  item,
  output logic               strobe,
  output pif_pkg::out_item_t result
);
  import pif_pkg::*;

  localparam int AW = $clog2(MAX_REF_VERTICES);
  localparam int CW = $clog2(MAX_REF_VERTICES + 1);

  state_t state, state_next;

  logic                      accept;
  logic                      op_run;
  logic [AW-1:0]             k;
  logic [CW-1:0]             ref_count;
  logic signed [COORD_W-1:0] prev_x, prev_y;
  logic                      prev_valid;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic signed [COORD_W-1:0] a1x, a1y, a2x, a2y;
  logic signed [OPA_W-1:0]   den, num;
  logic signed [PROD_W-1:0]  xn, yn, lo, hi;
  out_item_t                 new_res, pend;
  logic                      pend_valid;

  logic signed [DIFF_W-1:0]  dx, dy, ex, ey, wx, wy;
  logic signed [COORD_W-1:0] xmin, xmax;
  logic                      shared_a, shared_b, more;

  logic                      we;
  logic [AW-1:0]             raddr;
  logic [VERT_W-1:0]         rdata;
  logic signed [COORD_W-1:0] rx, ry;

  logic                      is_mul, is_div, mul_start, div_start;
  logic signed [OPA_W-1:0]   mul_a;
  logic signed [OPB_W-1:0]   mul_b;
  logic                      mul_done, div_done;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [COORD_W-1:0] div_q;

  assign accept = start && !busy;
  assign rx = $signed(rdata[VERT_W-1:COORD_W]);
  assign ry = $signed(rdata[COORD_W-1:0]);

  assign dx = DIFF_W'(cur_x) - DIFF_W'(prev_x);
  assign dy = DIFF_W'(cur_y) - DIFF_W'(prev_y);
  assign ex = DIFF_W'(a2x) - DIFF_W'(a1x);
  assign ey = DIFF_W'(a2y) - DIFF_W'(a1y);
  assign wx = DIFF_W'(a1x) - DIFF_W'(prev_x);
  assign wy = DIFF_W'(a1y) - DIFF_W'(prev_y);

  always_comb begin
    logic signed [COORD_W-1:0] qmin, qmax, amin, amax;
    qmin = (prev_x < cur_x) ? prev_x : cur_x;
    qmax = (prev_x > cur_x) ? prev_x : cur_x;
    amin = (a1x < a2x) ? a1x : a2x;
    amax = (a1x > a2x) ? a1x : a2x;
    xmin = (qmin > amin) ? qmin : amin;
    xmax = (qmax < amax) ? qmax : amax;
  end

  assign shared_a = (prev_x == a1x) && (prev_y == a1y);
  assign shared_b = (cur_x == a2x) && (cur_y == a2y);
  assign more     = (CW'(k) + CW'(2)) < ref_count;

  pif_ram #(.WIDTH(VERT_W), .DEPTH(MAX_REF_VERTICES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (ref_count[AW-1:0]),
    .wdata ({item.vx, item.vy}),
    .raddr (raddr),
    .rdata (rdata)
  );

  pif_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  pif_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     ((state == S_DIVY) ? yn : xn),
    .d     (den),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DEN1:  begin mul_a = OPA_W'(ey); mul_b = OPB_W'(dx); end
      S_DEN2:  begin mul_a = OPA_W'(ex); mul_b = OPB_W'(dy); end
      S_NUM1:  begin mul_a = OPA_W'(ey); mul_b = OPB_W'(wx); end
      S_NUM2:  begin mul_a = OPA_W'(ex); mul_b = OPB_W'(wy); end
      S_XN1:   begin mul_a = den;        mul_b = OPB_W'(prev_x); end
      S_XN2:   begin mul_a = num;        mul_b = OPB_W'(dx); end
      S_YN1:   begin mul_a = den;        mul_b = OPB_W'(prev_y); end
      S_YN2:   begin mul_a = num;        mul_b = OPB_W'(dy); end
      S_LO:    begin mul_a = den;        mul_b = OPB_W'(xmin); end
      S_HI:    begin mul_a = den;        mul_b = OPB_W'(xmax); end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && item.kind == KIND_NEXT && prev_valid && ref_count >= CW'(2)) begin
          state_next = S_RD0;
        end
      end
      S_RD0:  state_next = S_RD;
      S_RD:   state_next = S_SEG;
      S_SEG:  state_next = (shared_a || shared_b) ? S_HIT : S_DEN1;
      S_DEN1: if (mul_done) state_next = S_DEN2;
      S_DEN2: if (mul_done) state_next = S_DZ;
      S_DZ:   state_next = (den == '0) ? S_NEXT : S_NUM1;
      S_NUM1: if (mul_done) state_next = S_NUM2;
      S_NUM2: if (mul_done) state_next = S_XN1;
      S_XN1:  if (mul_done) state_next = S_XN2;
      S_XN2:  if (mul_done) state_next = S_YN1;
      S_YN1:  if (mul_done) state_next = S_YN2;
      S_YN2:  if (mul_done) state_next = S_NORM;
      S_NORM: state_next = S_LO;
      S_LO:   if (mul_done) state_next = S_HI;
      S_HI:   if (mul_done) state_next = S_CHK;
      S_CHK:  state_next = (xn > lo && xn < hi) ? S_DIVX : S_NEXT;
      S_DIVX: if (div_done) state_next = S_DIVY;
      S_DIVY: if (div_done) state_next = S_HIT;
      S_HIT:  state_next = S_NEXT;
      S_NEXT: state_next = more ? S_RD : S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != S_IDLE);
    we     = accept && item.kind == KIND_APPEND && ref_count < CW'(MAX_REF_VERTICES);
    is_mul = 1'b0;
    is_div = 1'b0;
    raddr  = '0;
    unique case (state)
      S_RD0:  raddr = AW'(1);
      S_NEXT: raddr = k + AW'(2);
      S_DEN1, S_DEN2, S_NUM1, S_NUM2, S_XN1, S_XN2,
      S_YN1, S_YN2, S_LO, S_HI: is_mul = 1'b1;
      S_DIVX, S_DIVY: is_div = 1'b1;
      default: raddr = '0;
    endcase
    mul_start = is_mul && !op_run;
    div_start = is_div && !op_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      op_run     <= 1'b0;
      ref_count  <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      prev_valid <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      if (mul_start || div_start) begin
        op_run <= 1'b1;
      end else if (mul_done || div_done) begin
        op_run <= 1'b0;
      end
      if (we) begin
        ref_count <= ref_count + 1'b1;
      end
      if (accept && item.kind == KIND_CLEAR) begin
        ref_count <= '0;
      end
      if (accept && (item.kind == KIND_START || (item.kind == KIND_NEXT && !prev_valid))) begin
        prev_x     <= item.vx;
        prev_y     <= item.vy;
        prev_valid <= 1'b1;
      end
      if (accept && item.kind == KIND_NEXT && prev_valid && ref_count < CW'(2)) begin
        prev_x <= item.vx;
        prev_y <= item.vy;
      end
      if (state == S_HIT) begin
        pend_valid <= 1'b1;
        strobe     <= pend_valid;
      end
      if (state == S_DONE) begin
        prev_x     <= cur_x;
        prev_y     <= cur_y;
        pend_valid <= 1'b0;
        strobe     <= pend_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x <= item.vx;
      cur_y <= item.vy;
      k     <= '0;
    end
    unique case (state)
      S_RD0: begin a1x <= rx; a1y <= ry; end
      S_RD:  begin a2x <= rx; a2y <= ry; end
      S_SEG: begin
        new_res.hit_x        <= shared_a ? prev_x : cur_x;
        new_res.hit_y        <= shared_a ? prev_y : cur_y;
        new_res.ref_segment  <= SEG_W'(k);
        new_res.shared_point <= 1'b1;
        new_res.last         <= 1'b0;
      end
      S_DEN1: if (mul_done) den <= OPA_W'(mul_p);
      S_DEN2: if (mul_done) den <= den - OPA_W'(mul_p);
      S_NUM1: if (mul_done) num <= OPA_W'(mul_p);
      S_NUM2: if (mul_done) num <= num - OPA_W'(mul_p);
      S_XN1:  if (mul_done) xn <= mul_p;
      S_XN2:  if (mul_done) xn <= xn + mul_p;
      S_YN1:  if (mul_done) yn <= mul_p;
      S_YN2:  if (mul_done) yn <= yn + mul_p;
      S_NORM: begin
        if (den < 0) begin
          den <= -den;
          xn  <= -xn;
          yn  <= -yn;
        end
      end
      S_LO:   if (mul_done) lo <= mul_p;
      S_HI:   if (mul_done) hi <= mul_p;
      S_DIVX: begin
        if (div_done) begin
          new_res.hit_x        <= div_q;
          new_res.ref_segment  <= SEG_W'(k);
          new_res.shared_point <= 1'b0;
          new_res.last         <= 1'b0;
        end
      end
      S_DIVY: if (div_done) new_res.hit_y <= div_q;
      S_HIT: begin
        pend   <= new_res;
        result <= pend;
      end
      S_NEXT: begin
        a1x <= a2x;
        a1y <= a2y;
        k   <= k + 1'b1;
      end
      S_DONE: begin
        result <= '{hit_x: pend.hit_x, hit_y: pend.hit_y,
                    ref_segment: pend.ref_segment,
                    shared_point: pend.shared_point, last: 1'b1};
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) (strobe && result.last) |-> !busy)
    else $error("final result strobed while walk still running");
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !pend_valid)
    else $error("pending result left behind in idle");
  assert property (@(posedge clk) disable iff (rst) ref_count <= CW'(MAX_REF_VERTICES))
    else $error("reference count beyond capacity");
  assert property (@(posedge clk) disable iff (rst) (mul_done || div_done) |-> op_run)
    else $error("arithmetic unit finished without a request");
  assert property (@(posedge clk) disable iff (rst) (state == S_SEG) |-> $past(state) == S_RD)
    else $error("segment test entered without a fresh vertex read");

endmodule

/* hdl/pif_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pif_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pif_mul.sv */
// Sequential signed shift-add multiplier, one multiplier bit per cycle.
// Depends on pif_pkg for operand and product widths.
module pif_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [pif_pkg::OPA_W-1:0]  a,
  input  logic signed [pif_pkg::OPB_W-1:0]  b,
  output logic                              done,
  output logic signed [pif_pkg::PROD_W-1:0] p
);
  import pif_pkg::*;

  localparam int CNT_W = $clog2(OPB_W);

  logic                     run;
  logic [CNT_W-1:0]         cnt;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] ash;
  logic [OPB_W-1:0]         bsh;
  logic                     last_step;

  assign last_step = (cnt == CNT_W'(OPB_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (last_step) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ash <= PROD_W'(a);
      bsh <= b;
    end else if (run) begin
      if (bsh[0]) begin
        acc <= last_step ? acc - ash : acc + ash;
      end
      ash <= ash <<< 1;
      bsh <= bsh >> 1;
    end
  end

  assign p = acc;

endmodule

/* hdl/pif_div.sv */
// Sequential restoring divider: signed numerator over positive denominator,
// quotient truncated toward zero and saturated to 32 bits. Depends on pif_pkg.
module pif_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [pif_pkg::PROD_W-1:0] n,
  input  logic [pif_pkg::OPA_W-1:0]         d,
  output logic                              done,
  output logic signed [pif_pkg::COORD_W-1:0] q
);
  import pif_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [QUO_W-1:0] Q_POS_MAX = QUO_W'(33'h0_7FFF_FFFF);
  localparam logic [QUO_W-1:0] Q_NEG_MAX = QUO_W'(33'h0_8000_0000);
  localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

  logic               chk;
  logic               run;
  logic               neg;
  logic               sat;
  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  r;
  logic [PROD_W-1:0]  dsh;
  logic [QUO_W-1:0]   qa;
  logic [PROD_W-1:0]  nabs;
  logic               ge;

  assign nabs = n[PROD_W-1] ? PROD_W'(-n) : PROD_W'(n);
  assign ge   = (r >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      chk  <= 1'b0;
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        chk <= 1'b1;
      end else if (chk) begin
        chk <= 1'b0;
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUO_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= nabs;
      neg <= n[PROD_W-1];
      dsh <= PROD_W'({d[OPA_W-2:0], {QUO_W{1'b0}}});
      qa  <= '0;
    end else if (chk) begin
      sat <= ge;
      dsh <= dsh >> 1;
    end else if (run) begin
      if (ge) begin
        r <= r - dsh;
      end
      qa  <= {qa[QUO_W-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

  always_comb begin
    if (neg) begin
      q = (sat || qa > Q_NEG_MAX) ? SAT_MIN : COORD_W'(-qa);
    end else begin
      q = (sat || qa > Q_POS_MAX) ? SAT_MAX : COORD_W'(qa);
    end
  end

endmodule
